// ===== rtl/retransmit_buffer_cumulative_ack_defines.svh =====
// assertion macros for the retransmit buffer
`ifndef RETRANSMIT_BUFFER_CUMULATIVE_ACK_DEFINES_SVH
`define RETRANSMIT_BUFFER_CUMULATIVE_ACK_DEFINES_SVH

// condition holds at every edge out of reset
`define RBCA_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RBCA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RBCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rbca_pkg.sv =====
// shared types and constants for the retransmit buffer
`default_nettype none

package rbca_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam logic [4:0]  CAPACITY_RESET  = 5'd16;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd200;
  localparam logic [7:0]  MAX_TRIES_RESET = 8'd25;
  localparam logic [7:0]  TRIES_SAT       = 8'hFF;

  localparam logic [1:0] CFG_CAPACITY  = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [1:0] CFG_MAX_TRIES = 2'd2;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_ACK  = 2'd1,
    MODE_TICK = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_ACCEPT    = 3'd0,
    KIND_OVERFLOW  = 3'd1,
    KIND_DUPLICATE = 3'd2,
    KIND_ACKED     = 3'd3,
    KIND_RESEND    = 3'd4,
    KIND_DONE      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ALU_EQ,
    ALU_BEFORE,
    ALU_TIMEOUT
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_CHK,
    S_DUP_RD,
    S_DUP_EV,
    S_PUSH_WR,
    S_TK_RD,
    S_TK_EV,
    S_CNT_RD,
    S_CNT_EV,
    S_GIVE_CHK,
    S_RM_RD,
    S_RM_EV,
    S_RM_END,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] seq;
    logic [15:0] handle;
    logic [15:0] length;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] handle;
    logic [15:0] length;
    logic [7:0]  tries;
    logic [31:0] sent;
  } entry_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [31:0] seq;
    logic [15:0] handle;
    logic [15:0] length;
    logic [4:0]  removed;
    logic        last;
  } emit_t;

  typedef struct packed {
    logic [4:0]  capacity;
    logic [15:0] timeout;
    logic [7:0]  max_tries;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/rbca_alu.sv =====
// shared subtract and compare unit for serial order, match and timeout tests
`default_nettype none

module rbca_alu (
  input  rbca_pkg::alu_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  input  logic [15:0]       limit,
  output logic              hit
);
  import rbca_pkg::*;

  logic [31:0] diff;

  assign diff = a - b;

  always_comb begin
    unique case (op)
      ALU_EQ:      hit = (diff == 32'd0);
      ALU_BEFORE:  hit = ~diff[31];
      ALU_TIMEOUT: hit = (diff > {16'd0, limit});
      default:     hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rbca_ctrl.sv =====
// sequencer and entry memory of the retransmit buffer
`default_nettype none

`include "retransmit_buffer_cumulative_ack_defines.svh"

module rbca_ctrl #(
  parameter int DEPTH = rbca_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  rbca_pkg::req_t  req,
  input  rbca_pkg::cfg_t  cfg,
  input  logic            out_free,
  output logic            busy,
  output rbca_pkg::emit_t emit
);
  import rbca_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;
  req_t   req_q, req_next;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] r, r_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] w, w_next;
  logic [CW-1:0] nx, nx_next;
  logic [CW-1:0] c, c_next;
  logic [CW-1:0] n, n_next;
  logic [CW-1:0] removed, removed_next;
  logic [31:0]   thr, thr_next;
  logic [CW-1:0] cap_eff;

  entry_t mem [DEPTH];
  entry_t rd_q;
  entry_t wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  alu_op_t     alu_op;
  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic        alu_hit;

  rbca_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .limit (cfg.timeout),
    .hit   (alu_hit)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    if (int'(cfg.capacity) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cfg.capacity);
    end
  end

  always_comb begin
    unique case (state)
      S_DUP_EV: begin
        alu_op = ALU_EQ;
        alu_a  = req_q.seq;
        alu_b  = rd_q.seq;
      end
      S_TK_EV: begin
        alu_op = ALU_TIMEOUT;
        alu_a  = req_q.now;
        alu_b  = rd_q.sent;
      end
      default: begin
        alu_op = ALU_BEFORE;
        alu_a  = thr;
        alu_b  = rd_q.seq;
      end
    endcase
  end

  always_comb begin
    state_next   = state;
    req_next     = req_q;
    count_next   = count;
    r_next       = r;
    j_next       = j;
    w_next       = w;
    nx_next      = nx;
    c_next       = c;
    n_next       = n;
    removed_next = removed;
    thr_next     = thr;
    rd_en        = 1'b0;
    rd_addr      = r[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = w[AW-1:0];
    wr_data      = rd_q;
    emit         = '0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          req_next     = req;
          r_next       = '0;
          n_next       = '0;
          removed_next = '0;
          thr_next     = req.seq;
          unique case (mode_t'(req.mode))
            MODE_PUSH: state_next = S_PUSH_CHK;
            MODE_ACK: begin
              j_next     = '0;
              w_next     = '0;
              nx_next    = '0;
              state_next = S_RM_RD;
            end
            MODE_TICK: state_next = S_TK_RD;
            default:   state_next = S_DONE;
          endcase
        end
      end

      S_PUSH_CHK: begin
        if (count >= cap_eff) begin
          emit.valid  = out_free;
          emit.kind   = KIND_OVERFLOW;
          emit.seq    = req_q.seq;
          emit.handle = req_q.handle;
          emit.length = req_q.length;
          if (out_free) begin
            state_next = S_DONE;
          end
        end else begin
          r_next     = '0;
          state_next = S_DUP_RD;
        end
      end

      S_DUP_RD: begin
        if (r < count) begin
          rd_en      = 1'b1;
          rd_addr    = r[AW-1:0];
          state_next = S_DUP_EV;
        end else begin
          state_next = S_PUSH_WR;
        end
      end

      S_DUP_EV: begin
        if (alu_hit) begin
          emit.valid  = out_free;
          emit.kind   = KIND_DUPLICATE;
          emit.seq    = req_q.seq;
          emit.handle = req_q.handle;
          emit.length = req_q.length;
          if (out_free) begin
            state_next = S_DONE;
          end
        end else begin
          r_next     = r + CW'(1);
          state_next = S_DUP_RD;
        end
      end

      S_PUSH_WR: begin
        emit.valid  = out_free;
        emit.kind   = KIND_ACCEPT;
        emit.seq    = req_q.seq;
        emit.handle = req_q.handle;
        emit.length = req_q.length;
        if (out_free) begin
          wr_en          = 1'b1;
          wr_addr        = count[AW-1:0];
          wr_data.seq    = req_q.seq;
          wr_data.handle = req_q.handle;
          wr_data.length = req_q.length;
          wr_data.tries  = '0;
          wr_data.sent   = req_q.now;
          count_next     = count + CW'(1);
          state_next     = S_DONE;
        end
      end

      S_TK_RD: begin
        if (r < count) begin
          rd_en      = 1'b1;
          rd_addr    = r[AW-1:0];
          state_next = S_TK_EV;
        end else begin
          state_next = S_DONE;
        end
      end

      S_TK_EV: begin
        if (!alu_hit) begin
          r_next     = r + CW'(1);
          state_next = S_TK_RD;
        end else if (rd_q.tries >= cfg.max_tries) begin
          thr_next   = rd_q.seq;
          j_next     = '0;
          c_next     = '0;
          state_next = S_CNT_RD;
        end else if (n == CW'(DEPTH)) begin
          state_next = S_DONE;
        end else begin
          emit.valid  = out_free;
          emit.kind   = KIND_RESEND;
          emit.seq    = rd_q.seq;
          emit.handle = rd_q.handle;
          emit.length = rd_q.length;
          if (out_free) begin
            wr_en        = 1'b1;
            wr_addr      = r[AW-1:0];
            wr_data.sent = req_q.now;
            if (rd_q.tries != TRIES_SAT) begin
              wr_data.tries = rd_q.tries + 8'd1;
            end
            n_next     = n + CW'(1);
            r_next     = r + CW'(1);
            state_next = S_TK_RD;
          end
        end
      end

      S_CNT_RD: begin
        if (j < count) begin
          rd_en      = 1'b1;
          rd_addr    = j[AW-1:0];
          state_next = S_CNT_EV;
        end else begin
          state_next = S_GIVE_CHK;
        end
      end

      S_CNT_EV: begin
        if (alu_hit) begin
          c_next = c + CW'(1);
        end
        j_next     = j + CW'(1);
        state_next = S_CNT_RD;
      end

      S_GIVE_CHK: begin
        if (({1'b0, n} + {1'b0, c}) > (CW + 1)'(DEPTH)) begin
          state_next = S_DONE;
        end else begin
          j_next     = '0;
          w_next     = '0;
          nx_next    = '0;
          state_next = S_RM_RD;
        end
      end

      S_RM_RD: begin
        if (j < count) begin
          rd_en      = 1'b1;
          rd_addr    = j[AW-1:0];
          state_next = S_RM_EV;
        end else begin
          state_next = S_RM_END;
        end
      end

      S_RM_EV: begin
        if (alu_hit) begin
          emit.valid  = out_free;
          emit.kind   = KIND_ACKED;
          emit.seq    = rd_q.seq;
          emit.handle = rd_q.handle;
          emit.length = rd_q.length;
          if (out_free) begin
            removed_next = removed + CW'(1);
            n_next       = n + CW'(1);
            j_next       = j + CW'(1);
            state_next   = S_RM_RD;
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = w[AW-1:0];
          w_next  = w + CW'(1);
          if (j <= r) begin
            nx_next = w + CW'(1);
          end
          j_next     = j + CW'(1);
          state_next = S_RM_RD;
        end
      end

      S_RM_END: begin
        count_next = w;
        if (req_q.mode == MODE_ACK) begin
          state_next = S_DONE;
        end else begin
          r_next     = nx;
          state_next = S_TK_RD;
        end
      end

      S_DONE: begin
        emit.valid   = out_free;
        emit.kind    = KIND_DONE;
        emit.removed = 5'(removed);
        emit.last    = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q   <= req_next;
    r       <= r_next;
    j       <= j_next;
    w       <= w_next;
    nx      <= nx_next;
    c       <= c_next;
    n       <= n_next;
    removed <= removed_next;
    thr     <= thr_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  `RBCA_ASSERT_NOW(a_count_bound, count <= CW'(DEPTH), "entry count above depth")
  `RBCA_ASSERT_IMP(a_emit_free, emit.valid, out_free, "item emitted into a full output")
  `RBCA_ASSERT_IMP(a_compact_order, (state == S_RM_EV) && wr_en, w <= j, "compaction overtook scan")
  `RBCA_ASSERT_IMP(a_tick_live, state == S_TK_EV, r < count, "tick test on a dead entry")
  `RBCA_ASSERT_NEXT(a_done_idle, emit.valid && (emit.kind == KIND_DONE), state == S_IDLE,
                    "sequencer not idle after done")

endmodule

`default_nettype wire

// ===== rtl/retransmit_buffer_cumulative_ack.sv =====
// top level of the retransmit buffer with cumulative ack
//
//   port group   direction  handshake              payload
//   request      in         req_valid / req_stall  mode seq_num buffer_handle packet_length now_ms
//   response     out        rsp_valid / rsp_stall  kind out_seq_num out_handle out_length
//                                                  removed_count last
//   config       in         cfg_write              cfg_index cfg_data
//
// each entry visit is a memory read, then one pass through the shared subtractor
// push: capacity check, duplicate scan over the entries held, then write (check only on overflow);
// ack: one removal pass over the entries held; tick: one scan, plus a count and a removal pass per give-up
// req_stall is high from accept until the done item leaves the sequencer
// a stalled response holds the sequencer at its next emitting step
// synchronous reset empties the table at once, no clearing pass
`default_nettype none

module retransmit_buffer_cumulative_ack #(
  parameter int DEPTH = rbca_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] seq_num,
  input  logic [15:0] buffer_handle,
  input  logic [15:0] packet_length,
  input  logic [31:0] now_ms,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  kind,
  output logic [31:0] out_seq_num,
  output logic [15:0] out_handle,
  output logic [15:0] out_length,
  output logic [4:0]  removed_count,
  output logic        last,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rbca_pkg::*;

  cfg_t  cfg;
  req_t  req;
  emit_t emit;
  logic  busy;
  logic  out_free;

  assign req.mode   = mode;
  assign req.seq    = seq_num;
  assign req.handle = buffer_handle;
  assign req.length = packet_length;
  assign req.now    = now_ms;

  assign out_free  = ~rsp_valid | ~rsp_stall;
  assign req_stall = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity  <= CAPACITY_RESET;
      cfg.timeout   <= TIMEOUT_RESET;
      cfg.max_tries <= MAX_TRIES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CAPACITY:  cfg.capacity  <= cfg_data[4:0];
        CFG_TIMEOUT:   cfg.timeout   <= cfg_data;
        CFG_MAX_TRIES: cfg.max_tries <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rbca_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .cfg       (cfg),
    .out_free  (out_free),
    .busy      (busy),
    .emit      (emit)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit.valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      kind          <= emit.kind;
      out_seq_num   <= emit.seq;
      out_handle    <= emit.handle;
      out_length    <= emit.length;
      removed_count <= emit.removed;
      last          <= emit.last;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for the retransmit buffer: directed and random items against a built-in predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rbca_pkg::*;

  localparam int          TABLE_DEPTH = DEPTH_DEFAULT;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] seq;
    logic [15:0] handle;
    logic [15:0] length;
    logic [4:0]  removed;
    logic        last;
  } response_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  mode;
  logic [31:0] seq_num;
  logic [15:0] buffer_handle;
  logic [15:0] packet_length;
  logic [31:0] now_ms;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [2:0]  kind;
  logic [31:0] out_seq_num;
  logic [15:0] out_handle;
  logic [15:0] out_length;
  logic [4:0]  removed_count;
  logic        last;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  retransmit_buffer_cumulative_ack dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .mode(mode), .seq_num(seq_num), .buffer_handle(buffer_handle),
    .packet_length(packet_length), .now_ms(now_ms),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .kind(kind), .out_seq_num(out_seq_num), .out_handle(out_handle),
    .out_length(out_length), .removed_count(removed_count), .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the packet table and registers
  logic [31:0] held_seq    [TABLE_DEPTH];
  logic [15:0] held_handle [TABLE_DEPTH];
  logic [15:0] held_length [TABLE_DEPTH];
  logic [7:0]  held_tries  [TABLE_DEPTH];
  logic [31:0] held_sent   [TABLE_DEPTH];
  int          held_count;
  logic [4:0]  cap_setting;
  logic [15:0] timeout_setting;
  logic [7:0]  tries_limit;

  response_t   awaited_responses[$];
  response_t   oldest_response;
  int          item_responses;
  int          error_count;
  int          cycle_count;
  int          send_idle_pct;
  int          stall_pct;
  int          hold_request;
  int          hold_left;
  logic [31:0] stream_seq;
  logic [31:0] stream_ms;

  function automatic bit covered_by(input logic [31:0] entry, input logic [31:0] acked);
    logic [31:0] gap;
    gap = acked - entry;
    return gap < 32'h8000_0000;
  endfunction

  function automatic void add_response(input kind_t k, input logic [31:0] s,
                                       input logic [15:0] h, input logic [15:0] l,
                                       input logic [4:0] r, input logic fin);
    response_t rsp;
    rsp.kind = k;
    rsp.seq = s;
    rsp.handle = h;
    rsp.length = l;
    rsp.removed = r;
    rsp.last = fin;
    awaited_responses.push_back(rsp);
    item_responses++;
  endfunction

  function automatic int count_covered(input logic [31:0] acked);
    int c;
    c = 0;
    for (int r = 0; r < held_count; r++)
      if (covered_by(held_seq[r], acked)) c++;
    return c;
  endfunction

  // drop covered entries in order; next_idx is where the scan resumes after pos
  function automatic int retire_upto(input logic [31:0] acked, input int pos,
                                     output int next_idx);
    int w;
    int gone;
    w = 0;
    gone = 0;
    next_idx = 0;
    for (int r = 0; r < held_count; r++) begin
      if (covered_by(held_seq[r], acked)) begin
        add_response(KIND_ACKED, held_seq[r], held_handle[r], held_length[r], 5'd0, 1'b0);
        gone++;
      end else begin
        held_seq[w] = held_seq[r];
        held_handle[w] = held_handle[r];
        held_length[w] = held_length[r];
        held_tries[w] = held_tries[r];
        held_sent[w] = held_sent[r];
        w++;
        if (r <= pos) next_idx = w;
      end
    end
    held_count = w;
    return gone;
  endfunction

  function automatic void compute_responses(input logic [1:0] m, input logic [31:0] s,
                                            input logic [15:0] h, input logic [15:0] l,
                                            input logic [31:0] t);
    int          limit;
    int          i;
    int          nx;
    int          removed;
    bit          dup;
    bit          scanning;
    logic [31:0] age;
    item_responses = 0;
    removed = 0;
    case (m)
      MODE_PUSH: begin
        limit = (cap_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(cap_setting);
        dup = 1'b0;
        if (held_count >= limit) begin
          add_response(KIND_OVERFLOW, s, h, l, 5'd0, 1'b0);
        end else begin
          for (int k = 0; k < held_count; k++)
            if (held_seq[k] == s) dup = 1'b1;
          if (dup) begin
            add_response(KIND_DUPLICATE, s, h, l, 5'd0, 1'b0);
          end else begin
            held_seq[held_count] = s;
            held_handle[held_count] = h;
            held_length[held_count] = l;
            held_tries[held_count] = 8'd0;
            held_sent[held_count] = t;
            held_count++;
            add_response(KIND_ACCEPT, s, h, l, 5'd0, 1'b0);
          end
        end
      end
      MODE_ACK: begin
        removed = retire_upto(s, 0, nx);
      end
      MODE_TICK: begin
        i = 0;
        scanning = 1'b1;
        while (scanning && i < held_count) begin
          age = t - held_sent[i];
          if (age <= {16'd0, timeout_setting}) begin
            i++;
          end else if (held_tries[i] >= tries_limit) begin
            if (item_responses + count_covered(held_seq[i]) > TABLE_DEPTH) begin
              scanning = 1'b0;
            end else begin
              removed += retire_upto(held_seq[i], i, nx);
              i = nx;
            end
          end else if (item_responses + 1 > TABLE_DEPTH) begin
            scanning = 1'b0;
          end else begin
            add_response(KIND_RESEND, held_seq[i], held_handle[i], held_length[i], 5'd0,
                         1'b0);
            held_sent[i] = t;
            if (held_tries[i] != TRIES_SAT) held_tries[i] = held_tries[i] + 8'd1;
            i++;
          end
        end
      end
      default: begin
      end
    endcase
    add_response(KIND_DONE, 32'd0, 16'd0, 16'd0, 5'(removed), 1'b1);
  endfunction

  task automatic flag_error(input string msg);
    $display("tb_top: error: %s", msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_responses.size() == 0) begin
        flag_error($sformatf("unexpected item kind %0d seq %h", kind, out_seq_num));
      end else begin
        oldest_response = awaited_responses.pop_front();
        if (kind !== oldest_response.kind || out_seq_num !== oldest_response.seq ||
            out_handle !== oldest_response.handle ||
            out_length !== oldest_response.length ||
            removed_count !== oldest_response.removed || last !== oldest_response.last)
          flag_error($sformatf({"got kind %0d seq %h handle %h len %h removed %0d last %b,",
                                " want kind %0d seq %h handle %h len %h removed %0d last %b"},
                               kind, out_seq_num, out_handle, out_length, removed_count, last,
                               oldest_response.kind, oldest_response.seq,
                               oldest_response.handle, oldest_response.length,
                               oldest_response.removed, oldest_response.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // response side stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      rsp_stall = 1'b1;
      hold_left--;
    end else begin
      rsp_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_item(input logic [1:0] m, input logic [31:0] s, input logic [15:0] h,
                           input logic [15:0] l, input logic [31:0] t);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    mode = m;
    seq_num = s;
    buffer_handle = h;
    packet_length = l;
    now_ms = t;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    compute_responses(m, s, h, l, t);
  endtask

  task automatic send_push(input logic [31:0] s, input logic [15:0] h, input logic [15:0] l,
                           input logic [31:0] t);
    send_item(MODE_PUSH, s, h, l, t);
  endtask

  task automatic send_ack(input logic [31:0] s);
    send_item(MODE_ACK, s, 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic send_tick(input logic [31:0] t);
    send_item(MODE_TICK, $urandom, 16'($urandom), 16'($urandom), t);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_valid = 1'b0;
    while (awaited_responses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    case (idx)
      CFG_CAPACITY:  cap_setting = data[4:0];
      CFG_TIMEOUT:   timeout_setting = data;
      CFG_MAX_TRIES: tries_limit = data[7:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  task automatic test_field_extremes();
    send_push(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 32'h0000_0000);
    send_push(32'h0000_0000, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    send_push(32'h0000_0000, 16'h1234, 16'h5678, 32'h0000_0010);
    send_item(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    // all ones sits exactly half the sequence space away and must stay
    send_ack(32'h7FFF_FFFF);
    send_tick(32'd200);
    send_tick(32'd201);
    send_ack(32'hFFFF_FFFF);
    send_ack(32'h0000_0000);
    wait_idle();
  endtask

  task automatic test_result_budget();
    write_reg(CFG_MAX_TRIES, 16'd1);
    send_push(32'd10, 16'hA000, 16'd64, 32'd100);
    send_push(32'd1000, 16'hA001, 16'd128, 32'd0);
    for (int k = 0; k < 14; k++)
      send_push(32'd20 + k, 16'hB000 + k, 16'd256 + k, 32'd0);
    send_push(32'd2000, 16'hC000, 16'd1, 32'd0);
    // full table and a repeated number: overflow wins
    send_push(32'd10, 16'hC001, 16'd2, 32'd0);
    wait_idle();
    write_reg(CFG_CAPACITY, 16'd5);
    send_push(32'd3000, 16'hC002, 16'd3, 32'd0);
    wait_idle();
    write_reg(CFG_CAPACITY, 16'd31);
    send_push(32'd3001, 16'hC003, 16'd4, 32'd0);
    send_tick(32'd250);
    // a resend then a give-up covering the whole table runs past the limit
    send_tick(32'd460);
    send_tick(32'd700);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_CAPACITY, 16'd0);
    send_push(32'd5, 16'h0005, 16'd5, 32'd0);
    wait_idle();
    write_reg(CFG_CAPACITY, 16'd1);
    write_reg(CFG_TIMEOUT, 16'd0);
    write_reg(CFG_MAX_TRIES, 16'd0);
    send_push(32'd7, 16'h0007, 16'd7, 32'd500);
    send_push(32'd8, 16'h0008, 16'd8, 32'd500);
    send_tick(32'd500);
    send_tick(32'd501);
    wait_idle();
    write_reg(CFG_CAPACITY, 16'd16);
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    write_reg(CFG_MAX_TRIES, 16'd255);
    send_push(32'd9, 16'h0009, 16'd9, 32'd0);
    send_tick(32'd65535);
    send_tick(32'd65536);
    send_ack(32'd9);
    wait_idle();
  endtask

  task automatic test_holdoff();
    set_idling(0, 0);
    write_reg(CFG_TIMEOUT, 16'd50);
    write_reg(CFG_MAX_TRIES, 16'd2);
    @(posedge clk);
    hold_request = 300;
    for (int k = 0; k < 6; k++)
      send_push(32'h8000_0000 + k, 16'($urandom), 16'($urandom), 32'd1000);
    send_tick(32'd1100);
    send_ack(32'h8000_0005);
    wait_idle();
  endtask

  task automatic random_traffic(input int count);
    int          pick;
    logic [31:0] s;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        s = (pick < 4) ? stream_seq - 32'd1 : stream_seq;
        if (pick >= 4) stream_seq = stream_seq + 32'd1;
        send_push(s, 16'($urandom), 16'($urandom), stream_ms);
        stream_ms = stream_ms + $urandom_range(0, 40);
      end else if (pick < 60) begin
        send_ack(stream_seq - $urandom_range(1, 6));
      end else if (pick < 92) begin
        stream_ms = stream_ms + $urandom_range(0, 2 * int'(timeout_setting) + 20);
        send_tick(stream_ms);
      end else begin
        send_item(2'($urandom_range(0, 3)), $urandom, 16'($urandom), 16'($urandom),
                  $urandom);
      end
    end
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct, input int count);
    wait_idle();
    write_reg(CFG_CAPACITY, 16'($urandom_range(1, 16)));
    write_reg(CFG_TIMEOUT, 16'($urandom_range(30, 250)));
    write_reg(CFG_MAX_TRIES, 16'($urandom_range(0, 3)));
    set_idling(send_pct, recv_pct);
    stream_seq = $urandom;
    stream_ms = $urandom;
    random_traffic(count);
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    mode = MODE_PUSH;
    seq_num = 32'd0;
    buffer_handle = 16'd0;
    packet_length = 16'd0;
    now_ms = 32'd0;
    rsp_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = CFG_CAPACITY;
    cfg_data = 16'd0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    held_count = 0;
    cap_setting = CAPACITY_RESET;
    timeout_setting = TIMEOUT_RESET;
    tries_limit = MAX_TRIES_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_field_extremes();
    test_result_budget();
    test_config_extremes();
    test_holdoff();
    test_random_phase(0, 0, 25);
    test_random_phase(47, 0, 25);
    test_random_phase(0, 47, 25);
    test_random_phase(8, 8, 25);

    repeat (50) @(posedge clk);
    if (error_count == 0 && awaited_responses.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
